/* rtl/core/plw_pkg.sv */
// Shared types, constants and controller/datapath command structs for the task watchdog.
package plw_pkg;

   localparam int NUM_TASKS  = 8;
   localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int TIME_W     = 32;
   localparam int MASK_W     = 32;
   localparam int COUNT_W    = 6;
   localparam int TASKNUM_W  = 8;
   localparam int MODE_W     = 2;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

   // request tdata layout
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_MODE_LO = 0;
   localparam int REQ_TASK_LO = REQ_MODE_LO + MODE_W;

   // response tdata layout
   localparam int RSP_TDATA_W  = 72;
   localparam int RSP_MASK_LO  = 0;
   localparam int RSP_COUNT_LO = RSP_MASK_LO + MASK_W;
   localparam int RSP_ALIVE_LO = RSP_COUNT_LO + COUNT_W;
   localparam int RSP_LAST_LO  = RSP_ALIVE_LO + 1;
   localparam int RSP_USED_W   = RSP_LAST_LO + TIME_W;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   // response kinds carried in tuser
   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_FEED  = 2'd1,
      MODE_CHECK = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef struct packed {
      logic tick;
      logic feed;
      logic start_check;
      logic start_query;
      logic step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

/* rtl/core/plw_ctrl.sv */
// Controller state machine: request acceptance, scan sequencing and response valid.
module plw_ctrl import plw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  mode_type      req_mode,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign accept     = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.tick        = accept && (req_mode == MODE_TICK);
      cmd.feed        = accept && (req_mode == MODE_FEED);
      cmd.start_check = accept && (req_mode == MODE_CHECK);
      cmd.start_query = accept && (req_mode == MODE_QUERY);
      cmd.step        = (state_ff == ST_SCAN);
      // output slot frees up in the same cycle the current response transfers
      cmd.load_out    = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_check || cmd.start_query) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (cmd.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/core/plw_datapath.sv */
// Datapath: ms counter, per-task feed stamps, config registers, scan unit, response register.
module plw_datapath import plw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [TASKNUM_W-1:0]   req_task,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   out_kind,
   output logic [MASK_W-1:0]      out_mask,
   output logic [COUNT_W-1:0]     out_count,
   output logic                   out_alive,
   output logic [TIME_W-1:0]      out_last
);

   localparam logic [TASK_IDX_W-1:0] LAST_IDX = TASK_IDX_W'(NUM_TASKS - 1);

   logic [TIME_W-1:0]     now_ff, now_in;
   logic [TIME_W-1:0]     stamp_ff [NUM_TASKS];
   logic                  enabled_ff, enabled_in;
   logic [TIME_W-1:0]     timeout_ff, timeout_in;

   logic [TASK_IDX_W-1:0] idx_ff, idx_in;
   logic                  query_ff, query_in;
   logic                  tvalid_ff, tvalid_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  alive_ff, alive_in;
   logic [TIME_W-1:0]     last_ff, last_in;

   logic                  kind_ff;
   logic [MASK_W-1:0]     omask_ff;
   logic [COUNT_W-1:0]    ocount_ff;
   logic                  oalive_ff;
   logic [TIME_W-1:0]     olast_ff;

   logic                  req_valid;
   logic [TASK_IDX_W-1:0] req_idx;
   logic [TIME_W-1:0]     stamp_rd;
   logic [TIME_W-1:0]     elapsed;
   logic                  miss;

   assign req_valid = (req_task < TASKNUM_W'(NUM_TASKS));
   assign req_idx   = req_task[TASK_IDX_W-1:0];

   // one stamp read per cycle, addressed by the scan index
   assign stamp_rd = stamp_ff[idx_ff];
   assign elapsed  = now_ff - stamp_rd;  // wraps modulo 2^32
   assign miss     = (elapsed >= timeout_ff);

   assign status.scan_done = query_ff || (idx_ff == LAST_IDX);

   always_comb begin
      now_in = now_ff;
      if (cmd.tick) now_in = now_ff + TIME_W'(1);
   end

   always_comb begin
      enabled_in = enabled_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLED: enabled_in = csr_wdata[0];
            CSR_TIMEOUT: timeout_in = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      query_in  = query_ff;
      tvalid_in = tvalid_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      alive_in  = alive_ff;
      last_in   = last_ff;
      if (cmd.start_check || cmd.start_query) begin
         idx_in    = cmd.start_query ? req_idx : '0;
         query_in  = cmd.start_query;
         tvalid_in = req_valid;
         mask_in   = '0;
         count_in  = '0;
         alive_in  = 1'b0;
         last_in   = '0;
      end else if (cmd.step) begin
         if (query_ff) begin
            alive_in = tvalid_ff && (!enabled_ff || !miss);
            last_in  = tvalid_ff ? stamp_rd : '0;
         end else begin
            if (enabled_ff && miss) begin
               mask_in  = mask_ff | (MASK_W'(1) << idx_ff);
               count_in = count_ff + COUNT_W'(1);
            end
            idx_in = idx_ff + TASK_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= '0;
         enabled_ff <= 1'b1;
         timeout_ff <= TIMEOUT_RESET;
         for (int i = 0; i < NUM_TASKS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         now_ff     <= now_in;
         enabled_ff <= enabled_in;
         timeout_ff <= timeout_in;
         if (cmd.feed && req_valid) begin
            stamp_ff[req_idx] <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      query_ff  <= query_in;
      tvalid_ff <= tvalid_in;
      mask_ff   <= mask_in;
      count_ff  <= count_in;
      alive_ff  <= alive_in;
      last_ff   <= last_in;
      if (cmd.load_out) begin
         kind_ff   <= query_ff ? KIND_QUERY : KIND_CHECK;
         omask_ff  <= mask_ff;
         ocount_ff <= count_ff;
         oalive_ff <= alive_ff;
         olast_ff  <= last_ff;
      end
   end

   assign out_kind  = kind_ff;
   assign out_mask  = omask_ff;
   assign out_count = ocount_ff;
   assign out_alive = oalive_ff;
   assign out_last  = olast_ff;

endmodule

/* rtl/core/per_task_liveness_watchdog_core.sv */
// Per-task liveness watchdog: top level joining the controller and the datapath.
//
// Usage:
//   req channel: one transfer per command; mode 0 ticks the ms counter, 1 feeds
//   task_index, 2 checks all tasks, 3 queries task_index.
//   rsp channel: one transfer for each check or query; tuser says which.
//   csr port: csr_we writes csr_index (0 enabled, 1 timeout_ms) at the edge.
// Timing:
//   Tick and feed keep the controller idle; req_tready stays high, so they can
//   follow back to back. A check walks the NUM_TASKS stamps one per cycle
//   through a single subtract-and-compare unit, then loads the output register
//   and returns to idle as it loads. A query uses the same unit once.
//   req_tready is low while a check or query is in flight.
// Reset: counter and stamps clear to zero, enabled = 1, timeout_ms = 5000.
// Stall: the response waits in its output register while new ticks and feeds
//   are still taken; the next check or query waits after its last step until
//   the pending response transfers.
module per_task_liveness_watchdog_core import plw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // mode[1:0], task_index[9:2], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // miss_mask, miss_count, task_alive,
                                               // last_feed_ms, zero pad
   output logic                   rsp_tuser,   // result_kind
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   mode_type              req_mode;
   logic [TASKNUM_W-1:0]  req_task;
   logic                  out_kind;
   logic [MASK_W-1:0]     out_mask;
   logic [COUNT_W-1:0]    out_count;
   logic                  out_alive;
   logic [TIME_W-1:0]     out_last;

   assign req_mode = mode_type'(req_tdata[REQ_MODE_LO +: MODE_W]);
   assign req_task = req_tdata[REQ_TASK_LO +: TASKNUM_W];

   plw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_mode),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   plw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_task  (req_task),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_kind  (out_kind),
      .out_mask  (out_mask),
      .out_count (out_count),
      .out_alive (out_alive),
      .out_last  (out_last)
   );

   assign rsp_tdata = {(RSP_TDATA_W - RSP_USED_W)'(0), out_last, out_alive, out_count, out_mask};
   assign rsp_tuser = out_kind;

`ifndef SYNTHESIS
   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_COUNT_LO +: COUNT_W] ==
                      COUNT_W'($countones(rsp_tdata[RSP_MASK_LO +: MASK_W]))))
      else $error("miss_count disagrees with miss_mask");

   a_query_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_QUERY)) |->
         (rsp_tdata[RSP_MASK_LO +: MASK_W] == '0))
      else $error("query response carries a miss mask");

   a_check_no_query_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_CHECK)) |->
         (!rsp_tdata[RSP_ALIVE_LO] && (rsp_tdata[RSP_LAST_LO +: TIME_W] == '0)))
      else $error("check response carries query fields");

   a_busy_after_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       ((req_tdata[REQ_MODE_LO +: MODE_W] == MODE_CHECK) ||
        (req_tdata[REQ_MODE_LO +: MODE_W] == MODE_QUERY))) |=> !req_tready)
      else $error("new request taken while a scan is in flight");
`endif

endmodule
